// File: rtl/ecal_pkg.sv
// Shared types, constants and small functions for the epoch to calendar converter.
// No dependencies; every other file in rtl imports this package.
package ecal_pkg;

    localparam int unsigned SECS_W   = 32;
    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned WDAY_W   = 3;

    localparam logic [31:0] DAY_SECS    = 32'd86400;
    localparam logic [31:0] HOUR_SECS   = 32'd3600;
    localparam logic [31:0] MINUTE_SECS = 32'd60;
    localparam logic [31:0] WEEK_DAYS   = 32'd7;
    localparam logic [11:0] BASE_YEAR   = 12'd1970;

    // Residues of the base year, kept as counters so the leap rule needs no divider.
    localparam logic [1:0] BASE_MOD4   = 2'd2;
    localparam logic [6:0] BASE_MOD100 = 7'd70;
    localparam logic [8:0] BASE_MOD400 = 9'd370;

    // Highest shift of the divisor in each long-division phase.
    localparam logic [3:0] DAYS_TOP_STEP = 4'd15;
    localparam logic [3:0] WDAY_TOP_STEP = 4'd13;
    localparam logic [3:0] HOUR_TOP_STEP = 4'd4;
    localparam logic [3:0] MIN_TOP_STEP  = 4'd5;

    localparam logic [3:0] LAST_MONTH = 4'd11;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAYS,
        S_WDAY,
        S_HOUR,
        S_MIN,
        S_YEAR,
        S_MONTH,
        S_DONE
    } ecal_state_t;

    // Result of the shared compare and subtract unit.
    typedef struct packed {
        logic        ge;
        logic [31:0] diff;
    } ecal_sub_t;

    // Length of month mon (0 = January) in days.
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        case (mon)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            4'd11:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // Day zero was a Thursday; map days mod 7 onto 1 = Monday .. 7 = Sunday.
    function automatic logic [2:0] weekday_of(input logic [2:0] days_mod7);
        logic [2:0] wd;
        case (days_mod7)
            3'd0:    wd = 3'd4;
            3'd1:    wd = 3'd5;
            3'd2:    wd = 3'd6;
            3'd3:    wd = 3'd7;
            3'd4:    wd = 3'd1;
            3'd5:    wd = 3'd2;
            3'd6:    wd = 3'd3;
            default: wd = 3'd1;
        endcase
        return wd;
    endfunction

endpackage

// File: rtl/ecal_ifs.sv
// Valid/ready channel interfaces for the epoch input and the calendar result.
// Depends on ecal_pkg for field widths.
interface ecal_epoch_if
    import ecal_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SECS_W-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ecal_date_if
    import ecal_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day_of_month;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
    logic [WDAY_W-1:0]   weekday;

    modport source (output valid, output year, output month, output day_of_month,
                    output hour, output minute, output second, output weekday,
                    input ready);
    modport sink   (input valid, input year, input month, input day_of_month,
                    input hour, input minute, input second, input weekday,
                    output ready);
endinterface

// File: rtl/ecal_subcmp.sv
// Shared 32-bit compare and subtract unit used by every phase of the converter.
// Depends on ecal_pkg for the result struct.
module ecal_subcmp
    import ecal_pkg::*;
(
    input  logic [31:0] a,
    input  logic [31:0] b,
    output ecal_sub_t   res
);

    logic [32:0] wide_diff;

    assign wide_diff = {1'b0, a} - {1'b0, b};
    assign res.ge    = ~wide_diff[32];
    assign res.diff  = wide_diff[31:0];

endmodule

// File: rtl/epoch_seconds_to_calendar.sv
// Converts an unsigned count of seconds since 1970-01-01 00:00:00 into the
// Gregorian date, time of day and weekday (1 = Monday .. 7 = Sunday). One item
// is worked at a time through a single 32-bit compare and subtract unit under
// a small sequencer: long divisions split off whole days, take the day count
// mod 7 and give hour and minute, then years are stepped from 1970 and months
// from January, and the result register is loaded once it is free. The input
// is ready whenever the sequencer is idle, even while a result still waits in
// the output register to be taken.
module epoch_seconds_to_calendar
    import ecal_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    ecal_epoch_if.sink         epoch,
    ecal_date_if.source        date
);

    ecal_state_t state_reg, state_next;

    logic [31:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [3:0]  step_reg, step_next;
    logic [15:0] days_reg, days_next;
    logic [16:0] tod_reg, tod_next;
    logic [2:0]  wmod_reg, wmod_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  minute_reg, minute_next;
    logic [5:0]  second_reg, second_next;
    logic [11:0] year_reg, year_next;
    logic [1:0]  m4_reg, m4_next;
    logic [6:0]  m100_reg, m100_next;
    logic [8:0]  m400_reg, m400_next;
    logic [3:0]  mon_reg, mon_next;

    logic        out_valid_reg, out_valid_next;
    logic [YEAR_W-1:0]   out_year_reg;
    logic [MONTH_W-1:0]  out_month_reg;
    logic [DAY_W-1:0]    out_day_reg;
    logic [HOUR_W-1:0]   out_hour_reg;
    logic [MINUTE_W-1:0] out_minute_reg;
    logic [SECOND_W-1:0] out_second_reg;
    logic [WDAY_W-1:0]   out_wday_reg;

    logic        leap;
    logic        last_step;
    logic        accept;
    logic        load_out;
    logic [31:0] op_b;
    ecal_sub_t   sub;

    assign leap      = ((m4_reg == 2'd0) && (m100_reg != 7'd0)) || (m400_reg == 9'd0);
    assign last_step = (step_reg == 4'd0);
    assign accept    = epoch.valid && epoch.ready;
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || date.ready);

    // Second operand of the shared unit: a shifted divisor during the long
    // divisions, a year length or a month length during the calendar walk.
    always_comb
    begin
        case (state_reg)
            S_DAYS:  op_b = DAY_SECS << step_reg;
            S_WDAY:  op_b = WEEK_DAYS << step_reg;
            S_HOUR:  op_b = HOUR_SECS << step_reg;
            S_MIN:   op_b = MINUTE_SECS << step_reg;
            S_YEAR:  op_b = leap ? 32'd366 : 32'd365;
            S_MONTH: op_b = {27'd0, month_len(mon_reg, leap)};
            default: op_b = 32'd0;
        endcase
    end

    ecal_subcmp u_subcmp (
        .a   (rem_reg),
        .b   (op_b),
        .res (sub)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_DAYS;
            S_DAYS:  if (last_step) state_next = S_WDAY;
            S_WDAY:  if (last_step) state_next = S_HOUR;
            S_HOUR:  if (last_step) state_next = S_MIN;
            S_MIN:   if (last_step) state_next = S_YEAR;
            S_YEAR:  if (!sub.ge) state_next = S_MONTH;
            S_MONTH: if (!sub.ge || (mon_reg == LAST_MONTH)) state_next = S_DONE;
            S_DONE:  if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath updates for each phase.
    always_comb
    begin
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        days_next   = days_reg;
        tod_next    = tod_reg;
        wmod_next   = wmod_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        year_next   = year_reg;
        m4_next     = m4_reg;
        m100_next   = m100_reg;
        m400_next   = m400_reg;
        mon_next    = mon_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rem_next  = epoch.epoch_seconds;
                    quo_next  = 16'd0;
                    step_next = DAYS_TOP_STEP;
                end
            end
            S_DAYS, S_WDAY, S_HOUR, S_MIN:
            begin
                // One restoring division step: keep the difference when it fits.
                if (sub.ge)
                begin
                    rem_next = sub.diff;
                end
                quo_next  = {quo_reg[14:0], sub.ge};
                step_next = step_reg - 4'd1;
                if (last_step)
                begin
                    quo_next = 16'd0;
                    case (state_reg)
                        S_DAYS:
                        begin
                            days_next = {quo_reg[14:0], sub.ge};
                            tod_next  = sub.ge ? sub.diff[16:0] : rem_reg[16:0];
                            rem_next  = {16'd0, quo_reg[14:0], sub.ge};
                            step_next = WDAY_TOP_STEP;
                        end
                        S_WDAY:
                        begin
                            wmod_next = sub.ge ? sub.diff[2:0] : rem_reg[2:0];
                            rem_next  = {15'd0, tod_reg};
                            step_next = HOUR_TOP_STEP;
                        end
                        S_HOUR:
                        begin
                            hour_next = {quo_reg[3:0], sub.ge};
                            step_next = MIN_TOP_STEP;
                        end
                        default:
                        begin
                            minute_next = {quo_reg[4:0], sub.ge};
                            second_next = sub.ge ? sub.diff[5:0] : rem_reg[5:0];
                            rem_next    = {16'd0, days_reg};
                            year_next   = BASE_YEAR;
                            m4_next     = BASE_MOD4;
                            m100_next   = BASE_MOD100;
                            m400_next   = BASE_MOD400;
                        end
                    endcase
                end
            end
            S_YEAR:
            begin
                if (sub.ge)
                begin
                    rem_next  = sub.diff;
                    year_next = year_reg + 12'd1;
                    m4_next   = m4_reg + 2'd1;
                    m100_next = (m100_reg == 7'd99) ? 7'd0 : m100_reg + 7'd1;
                    m400_next = (m400_reg == 9'd399) ? 9'd0 : m400_reg + 9'd1;
                end
                else
                begin
                    mon_next = 4'd0;
                end
            end
            S_MONTH:
            begin
                // December takes whatever is left; earlier months subtract while they fit.
                if (sub.ge && (mon_reg != LAST_MONTH))
                begin
                    rem_next = sub.diff;
                    mon_next = mon_reg + 4'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (date.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        days_reg   <= days_next;
        tod_reg    <= tod_next;
        wmod_reg   <= wmod_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        year_reg   <= year_next;
        m4_reg     <= m4_next;
        m100_reg   <= m100_next;
        m400_reg   <= m400_next;
        mon_reg    <= mon_next;
        if (load_out)
        begin
            out_year_reg   <= year_reg;
            out_month_reg  <= mon_reg + 4'd1;
            out_day_reg    <= rem_reg[4:0] + 5'd1;
            out_hour_reg   <= hour_reg;
            out_minute_reg <= minute_reg;
            out_second_reg <= second_reg;
            out_wday_reg   <= weekday_of(wmod_reg);
        end
    end

    assign epoch.ready       = (state_reg == S_IDLE);
    assign date.valid        = out_valid_reg;
    assign date.year         = out_year_reg;
    assign date.month        = out_month_reg;
    assign date.day_of_month = out_day_reg;
    assign date.hour         = out_hour_reg;
    assign date.minute       = out_minute_reg;
    assign date.second       = out_second_reg;
    assign date.weekday      = out_wday_reg;

    // The year walk never passes the last year a 32-bit count can reach.
    a_year_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_YEAR) |-> (year_reg <= 12'd2106))
        else $error("year walk ran past 2106");

    // The month walk stops at December.
    a_month_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MONTH) |-> (mon_reg <= LAST_MONTH))
        else $error("month index out of range");

    // Hour, minute and second from the divisions stay in range before the calendar walk.
    a_time_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_YEAR) |-> ((hour_reg < 5'd24) && (minute_reg < 6'd60)
                                   && (second_reg < 6'd60)))
        else $error("time of day out of range");

    // A new result only appears right after the sequencer finished an item.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(date.valid) |-> $past(state_reg == S_DONE))
        else $error("result raised without a finished item");

endmodule

// File: test/tb_epoch_seconds_to_calendar.sv
`timescale 1ns / 100ps
// Self-checking testbench for epoch_seconds_to_calendar: random and directed epoch
// counts, predicted calendar dates compared field by field. Needs ecal_pkg, ecal_ifs and the rtl converter.
module tb_epoch_seconds_to_calendar;
    import ecal_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned RANDOM_ITEMS  = 800;
    localparam int unsigned DRAIN_EVERY   = 200;
    localparam int unsigned SETTLE_CYCLES = 250;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day_of_month;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
        logic [WDAY_W-1:0]   weekday;
    } cal_date_t;

    typedef struct {
        logic [SECS_W-1:0] secs;
        bit                drain_first;
    } epoch_item_t;

    logic clk;
    logic rst_n;

    ecal_epoch_if epoch_ch ();
    ecal_date_if  date_ch ();

    epoch_item_t pending_epochs[$];
    cal_date_t   expected_dates[$];

    int unsigned n_total;
    int unsigned n_directed;
    int unsigned n_in;
    int unsigned n_out;
    int unsigned n_errors;
    int unsigned n_pauses;
    int unsigned n_cycles;
    int unsigned min_year;
    int unsigned max_year;

    epoch_seconds_to_calendar u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .epoch (epoch_ch),
        .date  (date_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned year_days(input int unsigned y);
        return is_leap_year(y) ? 366 : 365;
    endfunction

    // Month index m0 counts from 0 = January.
    function automatic int unsigned month_days(input int unsigned m0, input int unsigned y);
        int unsigned lens[12];
        lens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m0 == 1 && is_leap_year(y))
            return 29;
        return lens[m0];
    endfunction

    // Day d may run past the end of month m; it is just added as an offset.
    function automatic logic [SECS_W-1:0] epoch_of(input int unsigned y, input int unsigned m,
                                                   input int unsigned d, input int unsigned tod);
        longint unsigned days;
        days = 0;
        for (int unsigned yy = 1970; yy < y; yy++)
            days += year_days(yy);
        for (int unsigned mm = 0; mm + 1 < m; mm++)
            days += month_days(mm, y);
        days += d - 1;
        return SECS_W'(days * 86400 + tod);
    endfunction

    function automatic cal_date_t calendar_of(input logic [SECS_W-1:0] secs);
        int unsigned days;
        int unsigned tod;
        int unsigned yr;
        int unsigned mon;
        int unsigned p;
        int unsigned w;
        cal_date_t   d;
        days = secs / DAY_SECS;
        tod  = secs % DAY_SECS;
        yr   = 1970;
        while (days >= year_days(yr))
        begin
            days -= year_days(yr);
            yr++;
        end
        mon = 0;
        while (mon < 11 && days >= month_days(mon, yr))
        begin
            days -= month_days(mon, yr);
            mon++;
        end
        mon  += 1;
        days += 1;
        // January and February count as months of the previous year.
        if (mon < 3)
        begin
            p = yr - 1;
            w = ((23 * mon) / 9 + days + 4 + yr + p / 4 - p / 100 + p / 400) % 7;
        end
        else
            w = ((23 * mon) / 9 + days + 4 + yr + yr / 4 - yr / 100 + yr / 400 - 2) % 7;
        d.year         = YEAR_W'(yr);
        d.month        = MONTH_W'(mon);
        d.day_of_month = DAY_W'(days);
        d.hour         = HOUR_W'(tod / 3600);
        d.minute       = MINUTE_W'((tod % 3600) / 60);
        d.second       = SECOND_W'(tod % 60);
        d.weekday      = WDAY_W'((w == 0) ? 7 : w);
        return d;
    endfunction

    // Half plain 32-bit patterns, half dates pushed onto year and month edges.
    function automatic logic [SECS_W-1:0] random_epoch();
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned tod;
        y = $urandom_range(2105, 1970);
        m = $urandom_range(12, 1);
        case ($urandom_range(2))
            0:       tod = 0;
            1:       tod = 86399;
            default: tod = $urandom_range(86399);
        endcase
        case ($urandom_range(3))
            2:
            begin
                m = 1;
                case ($urandom_range(5))
                    0:       d = 1;
                    1:       d = 59;
                    2:       d = 60;
                    3:       d = year_days(y);
                    4:       d = year_days(y) - 1;
                    default: d = $urandom_range(year_days(y), 1);
                endcase
            end
            3:       d = $urandom_range(1) ? 1 : month_days(m - 1, y);
            default: return $urandom();
        endcase
        return epoch_of(y, m, d, tod);
    endfunction

    function automatic int unsigned idle_phase();
        if (n_total == 0)
            return 0;
        return (n_in * 4 / n_total > 3) ? 3 : n_in * 4 / n_total;
    endfunction

    function automatic bit sender_idles(input int unsigned ph);
        case (ph)
            1:       return $urandom_range(99) < 74;
            3:       return $urandom_range(99) < 38;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls(input int unsigned ph);
        case (ph)
            2:       return $urandom_range(99) < 74;
            3:       return $urandom_range(99) < 38;
            default: return 1'b0;
        endcase
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    task automatic add_epoch(input logic [SECS_W-1:0] secs, input bit drain_first);
        epoch_item_t it;
        it.secs        = secs;
        it.drain_first = drain_first;
        pending_epochs.push_back(it);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_epochs
        bit fire;
        bit hold;
        if (!rst_n)
        begin
            epoch_ch.valid         <= 1'b0;
            epoch_ch.epoch_seconds <= '0;
        end
        else
        begin
            fire = epoch_ch.valid && epoch_ch.ready;
            if (fire)
            begin
                expected_dates.push_back(calendar_of(epoch_ch.epoch_seconds));
                n_in++;
            end
            // An item not yet taken stays on the bus unchanged.
            if (!epoch_ch.valid || fire)
            begin
                hold = pending_epochs.size() == 0 || sender_idles(idle_phase()) ||
                       (pending_epochs[0].drain_first && expected_dates.size() != 0);
                if (hold)
                    epoch_ch.valid <= 1'b0;
                else
                begin
                    epoch_ch.valid         <= 1'b1;
                    epoch_ch.epoch_seconds <= pending_epochs[0].secs;
                    if (pending_epochs[0].drain_first)
                        n_pauses++;
                    void'(pending_epochs.pop_front());
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_dates
        cal_date_t got;
        cal_date_t want;
        if (!rst_n)
            date_ch.ready <= 1'b0;
        else
        begin
            if (date_ch.valid && date_ch.ready)
            begin
                got.year         = date_ch.year;
                got.month        = date_ch.month;
                got.day_of_month = date_ch.day_of_month;
                got.hour         = date_ch.hour;
                got.minute       = date_ch.minute;
                got.second       = date_ch.second;
                got.weekday      = date_ch.weekday;
                if (expected_dates.size() == 0)
                begin
                    $error("result with no item outstanding: %0d-%0d-%0d", got.year,
                           got.month, got.day_of_month);
                    n_errors++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    check_field("year", want.year, got.year);
                    check_field("month", want.month, got.month);
                    check_field("day_of_month", want.day_of_month, got.day_of_month);
                    check_field("hour", want.hour, got.hour);
                    check_field("minute", want.minute, got.minute);
                    check_field("second", want.second, got.second);
                    check_field("weekday", want.weekday, got.weekday);
                end
                n_out++;
                if (got.year < min_year)
                    min_year = got.year;
                if (got.year > max_year)
                    max_year = got.year;
            end
            date_ch.ready <= !receiver_stalls(idle_phase());
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding", n_cycles,
                     expected_dates.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        epoch_ch.valid         = 1'b0;
        epoch_ch.epoch_seconds = '0;
        date_ch.ready          = 1'b0;
        min_year               = 4095;
        max_year               = 0;

        // Edges of the input range, of days, of years and of the leap rules.
        add_epoch(32'h0000_0000, 1'b0);
        add_epoch(32'hFFFF_FFFF, 1'b0);
        add_epoch(epoch_of(1970, 1, 1, 86399), 1'b0);
        add_epoch(epoch_of(1970, 1, 2, 0), 1'b0);
        add_epoch(epoch_of(1970, 12, 31, 86399), 1'b0);
        add_epoch(epoch_of(1971, 1, 1, 0), 1'b0);
        add_epoch(epoch_of(1972, 2, 28, 43200), 1'b0);
        add_epoch(epoch_of(1972, 2, 29, 0), 1'b0);
        add_epoch(epoch_of(1972, 3, 1, 0), 1'b0);
        // The last day of a leap year must not roll into the next year.
        add_epoch(epoch_of(1972, 12, 31, 0), 1'b0);
        add_epoch(epoch_of(1972, 12, 31, 86399), 1'b0);
        add_epoch(epoch_of(1973, 1, 1, 0), 1'b0);
        add_epoch(epoch_of(2000, 2, 29, 3661), 1'b0);
        add_epoch(epoch_of(2000, 12, 31, 86399), 1'b0);
        add_epoch(epoch_of(2001, 1, 1, 0), 1'b0);
        add_epoch(epoch_of(2100, 2, 28, 86399), 1'b0);
        add_epoch(epoch_of(2100, 3, 1, 0), 1'b0);
        add_epoch(epoch_of(2106, 2, 7, 0), 1'b0);
        add_epoch(32'h7FFF_FFFF, 1'b0);
        add_epoch(32'h8000_0000, 1'b0);
        add_epoch(32'hAAAA_AAAA, 1'b0);
        add_epoch(32'h5555_5555, 1'b0);
        add_epoch(epoch_of(2024, 6, 15, 45296), 1'b0);
        n_directed = pending_epochs.size();
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
            add_epoch(random_epoch(), i % DRAIN_EVERY == 0);
        n_total = pending_epochs.size();

        repeat (8) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (pending_epochs.size() != 0 || epoch_ch.valid || expected_dates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Converted %0d epoch counts (%0d directed, %0d random), years %0d to %0d.",
                 n_out, n_directed, n_total - n_directed, min_year, max_year);
        $display("Ran free, sender-idle, receiver-stall and mixed phases; %0d full drains, %0d cycles.",
                 n_pauses, n_cycles);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
